@@ rtl/mtafc_pkg.sv @@
// package for the minute temperature averager with fan control
// holds payload structs, divider request/response structs and shared constants
// no dependencies
`timescale 1ns / 1ps

package mtafc_pkg;

    localparam int TEMP_W      = 16;
    localparam int SUM_W       = 23;
    localparam int CNT_W       = 7;
    localparam int MAG_W       = SUM_W - 1;
    localparam int ITER_W      = 5;
    localparam int LOGIDX_W    = 11;
    localparam int POWER_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CNT_W-1:0]   MAX_SAMPLES   = 7'd64;
    localparam logic [POWER_W-1:0] FAN_POWER_MAX = 4'd9;
    localparam logic [POWER_W-1:0] FAN_POWER_RST = 4'd1;
    localparam logic [POWER_W-1:0] MOTOR_STOP    = 4'd0;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FAN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_POWER     = 2'd2;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic        [5:0]        seconds;
        logic        [5:0]        minutes;
        logic        [4:0]        hours;
        logic                     motor_running;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0]   current_temp;
        logic                       log_valid;
        logic        [LOGIDX_W-1:0] log_index;
        logic signed [TEMP_W-1:0]   log_average;
        logic                       motor_cmd_valid;
        logic        [POWER_W-1:0]  motor_power;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [TEMP_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/mtafc_div.sv @@
// serial restoring divider, one quotient bit per cycle
// divides a sum magnitude by the sample count, applies the sign at the end
// depends on mtafc_pkg
`timescale 1ns / 1ps

module mtafc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtafc_pkg::t_div_req i_req,
    output mtafc_pkg::t_div_rsp o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [mtafc_pkg::ITER_W-1:0]      r_iter;
    logic [mtafc_pkg::MAG_W-1:0]       r_q;
    logic [mtafc_pkg::CNT_W-1:0]       r_rem;
    logic [mtafc_pkg::CNT_W-1:0]       r_divisor;
    logic                              r_neg;

    logic [mtafc_pkg::CNT_W:0]         rem_shift;
    logic [mtafc_pkg::CNT_W:0]         rem_diff;
    logic                              fits;
    logic [mtafc_pkg::MAG_W-1:0]       q_signed;

    assign rem_shift = {r_rem, r_q[mtafc_pkg::MAG_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_divisor};
    assign fits      = rem_shift >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                if (r_iter == mtafc_pkg::ITER_W'(mtafc_pkg::MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    // datapath: dividend shifts out on top while quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q       <= i_req.mag;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
            r_neg     <= i_req.neg;
        end else if (r_busy) begin
            r_q   <= {r_q[mtafc_pkg::MAG_W-2:0], fits};
            r_rem <= fits ? rem_diff[mtafc_pkg::CNT_W-1:0]
                          : rem_shift[mtafc_pkg::CNT_W-1:0];
        end
    end

    // truncation toward zero: quotient takes the sign of the sum
    assign q_signed       = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = q_signed[mtafc_pkg::TEMP_W-1:0];

endmodule

@@ rtl/minute_temp_average_fan_control_unit.sv @@
// top level of the minute temperature averager with fan control
// sequencer, sample accumulator, fan decision, output register
// depends on mtafc_pkg and mtafc_div
`timescale 1ns / 1ps

// Each accepted transaction is one one-second tick: the sample is summed and
// counted (up to 64 samples, later ones are dropped), and on a tick whose
// seconds is zero a log entry with index hours*60+minutes and the truncated
// mean is produced and the accumulator cleared. In auto mode the sample is
// compared with the threshold to start or stop the fan. Every tick yields
// exactly one result. A tick without a log goes from the pending register
// through the emit state into the result register; a logging tick first
// waits in the divide state for the serial divider, which produces one
// quotient bit per cycle over 22 bits and hands the quotient to the pending
// register. Input stall stays high while a tick is in work and while its
// finished result waits for the output register to free up. Configuration
// writes are always ready.
module minute_temp_average_fan_control_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mtafc_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mtafc_pkg::t_out_item                o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mtafc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mtafc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic signed [mtafc_pkg::TEMP_W-1:0]  r_threshold;
    logic                                 r_auto_mode;
    logic [mtafc_pkg::POWER_W-1:0]        r_fan_power;

    logic signed [mtafc_pkg::SUM_W-1:0]   r_sum;
    logic [mtafc_pkg::CNT_W-1:0]          r_count;

    mtafc_pkg::t_out_item                 r_pend;
    mtafc_pkg::t_out_item                 r_out;
    logic                                 r_out_valid;

    logic                                 in_accept;
    logic                                 cfg_write;
    logic                                 take_sample;
    logic                                 is_log;
    logic signed [mtafc_pkg::SUM_W-1:0]   sum_acc;
    logic [mtafc_pkg::CNT_W-1:0]          count_acc;
    logic [mtafc_pkg::SUM_W-1:0]          sum_neg;
    logic [mtafc_pkg::LOGIDX_W-1:0]       log_idx;
    logic                                 fan_start;
    logic                                 fan_halt;
    logic [mtafc_pkg::POWER_W-1:0]        start_power;
    logic                                 out_free;

    mtafc_pkg::t_div_req                  div_req;
    mtafc_pkg::t_div_rsp                  div_rsp;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;

    // accumulate, dropping samples once the count is full
    assign take_sample = r_count < mtafc_pkg::MAX_SAMPLES;
    assign sum_acc     = take_sample ? r_sum + mtafc_pkg::SUM_W'(i_in_item.temperature)
                                     : r_sum;
    assign count_acc   = take_sample ? r_count + 1'b1 : r_count;
    assign is_log      = (i_in_item.seconds == 6'd0);
    assign sum_neg     = -sum_acc;

    // hours*60 as hours*64 - hours*4
    assign log_idx = (mtafc_pkg::LOGIDX_W'(i_in_item.hours) << 6)
                   - (mtafc_pkg::LOGIDX_W'(i_in_item.hours) << 2)
                   + mtafc_pkg::LOGIDX_W'(i_in_item.minutes);

    assign fan_start   = r_auto_mode && !i_in_item.motor_running
                      && (i_in_item.temperature > r_threshold);
    assign fan_halt    = r_auto_mode && i_in_item.motor_running
                      && (i_in_item.temperature < r_threshold);
    assign start_power = (r_fan_power > mtafc_pkg::FAN_POWER_MAX) ? mtafc_pkg::FAN_POWER_MAX
                                                                  : r_fan_power;

    assign div_req.start   = in_accept && is_log;
    assign div_req.neg     = sum_acc[mtafc_pkg::SUM_W-1];
    assign div_req.mag     = sum_acc[mtafc_pkg::SUM_W-1] ? sum_neg[mtafc_pkg::MAG_W-1:0]
                                                         : sum_acc[mtafc_pkg::MAG_W-1:0];
    assign div_req.divisor = count_acc;

    mtafc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = is_log ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                if (div_rsp.done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= '0;
            r_auto_mode <= 1'b0;
            r_fan_power <= mtafc_pkg::FAN_POWER_RST;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_write) begin
                case (i_cfg_index)
                    mtafc_pkg::REG_FAN_THRESHOLD: r_threshold <= i_cfg_data;
                    mtafc_pkg::REG_AUTO_MODE:     r_auto_mode <= i_cfg_data[0];
                    mtafc_pkg::REG_FAN_POWER:     r_fan_power <= i_cfg_data[mtafc_pkg::POWER_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_sum   <= is_log ? '0 : sum_acc;
                r_count <= is_log ? '0 : count_acc;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pend.current_temp    <= i_in_item.temperature;
            r_pend.log_valid       <= is_log;
            r_pend.log_index       <= is_log ? log_idx : '0;
            r_pend.log_average     <= '0;
            r_pend.motor_cmd_valid <= fan_start || fan_halt;
            r_pend.motor_power     <= fan_start ? start_power : mtafc_pkg::MOTOR_STOP;
        end else if (r_state == S_DIV && div_rsp.done) begin
            r_pend.log_average <= div_rsp.quotient;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide state");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mtafc_pkg::MAX_SAMPLES)
        else $error("sample count above capacity");

    a_plain_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !is_log) |=> (r_state == S_EMIT))
        else $error("tick without log did not go to emit");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> o_out_valid)
        else $error("emitted transaction not shown at output");

endmodule
